@@ rtl/stq_pkg.sv @@
// Shared types, codes and field layout for the sorted timer queue.
`default_nettype none
package stq_pkg;

  localparam int ACTION_W    = 2;
  localparam int DELAY_W     = 32;
  localparam int ABS_W       = 48;
  localparam int CANCEL_ID_W = 16;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int RID_W       = 16;

  localparam int DELAY_LSB  = 0;
  localparam int REPEAT_BIT = DELAY_LSB + DELAY_W;
  localparam int ABS_LSB    = REPEAT_BIT + 1;
  localparam int CID_LSB    = ABS_LSB + ABS_W;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - RID_W;

  // most expiries reported for one tick
  localparam int RESULT_CAP = 16;
  localparam int K_W        = $clog2(RESULT_CAP + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD_REL = 2'd0,
    ACT_ADD_ABS = 2'd1,
    ACT_CANCEL  = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_EXPIRE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RES_ADD_OK   = 3'd0,
    RES_FULL     = 3'd1,
    RES_CAN_OK   = 3'd2,
    RES_CAN_MISS = 3'd3,
    RES_EXPIRE   = 3'd4
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     ins_step;
    logic     can_step;
    logic     pop;
    logic     push;
    logic     last;
    res_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic ins_stop;
    logic can_end;
    logic can_hit;
    logic due;
    logic head_rep;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/stq_dp.sv @@
// Timer table datapath: sorted entry registers, clock, id counter and output register.
`default_nettype none
module stq_dp #(
  parameter int DEPTH     = 16,
  parameter int ID_BITS   = 16,
  parameter int TIME_BITS = 48
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  stq_pkg::cmd_t                     cmd,
  output stq_pkg::sts_t                     sts,
  input  stq_pkg::action_t                  in_action,
  input  wire  [stq_pkg::IN_DATA_W-1:0]     in_data,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [stq_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [stq_pkg::KIND_W-1:0]        out_tuser,
  output logic                              out_tlast
);
  import stq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int PTR_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (ID_BITS > CANCEL_ID_W) ? ID_BITS : CANCEL_ID_W;

  logic [TIME_BITS-1:0]   time_r;
  logic [ID_BITS-1:0]     next_id_r;
  logic [PTR_W-1:0]       cnt_r;
  logic [PTR_W-1:0]       ptr_r;
  logic [TIME_BITS-1:0]   exp_r [DEPTH];
  logic [ID_BITS-1:0]     id_r  [DEPTH];
  logic [DELAY_W-1:0]     per_r [DEPTH];
  logic                   rep_r [DEPTH];
  logic [TIME_BITS-1:0]   ins_exp_r;
  logic [ID_BITS-1:0]     ins_id_r;
  logic [DELAY_W-1:0]     ins_per_r;
  logic                   ins_rep_r;
  logic [CANCEL_ID_W-1:0] cid_r;
  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [RID_W-1:0]       out_id_r;
  logic [KIND_W-1:0]      out_kind_r;
  logic                   out_last_r;

  logic [DELAY_W-1:0]     delay;
  logic                   repeat_req;
  logic [ABS_W-1:0]       abs_time;
  logic [CANCEL_ID_W-1:0] cancel_id;
  logic [ID_BITS-1:0]     nid;
  logic [TIME_BITS-1:0]   rel_exp;
  logic [TIME_BITS-1:0]   pop_exp;
  logic [DELAY_W-1:0]     head_per;
  logic [IDX_W-1:0]       pidx;
  logic [PTR_W-1:0]       rem_ptr;
  logic                   full;
  logic                   ptr_end;
  logic                   ins_stop;
  logic                   can_hit;
  logic                   do_ins;
  logic                   do_rem;
  logic                   is_add;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [DELAY_W-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS + 1)'(b);
    sat_add = s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  assign delay      = in_data[DELAY_LSB +: DELAY_W];
  assign repeat_req = in_data[REPEAT_BIT];
  assign abs_time   = in_data[ABS_LSB +: ABS_W];
  assign cancel_id  = in_data[CID_LSB +: CANCEL_ID_W];

  assign nid      = (next_id_r == {ID_BITS{1'b1}}) ? ID_BITS'(1) : next_id_r + ID_BITS'(1);
  assign rel_exp  = sat_add(time_r, delay);
  assign head_per = (per_r[0] == '0) ? DELAY_W'(1) : per_r[0];
  assign pop_exp  = sat_add(exp_r[0], head_per);
  assign pidx     = ptr_r[IDX_W-1:0];
  assign full     = cnt_r == PTR_W'(DEPTH);
  assign ptr_end  = ptr_r == cnt_r;
  assign ins_stop = ptr_end || (exp_r[pidx] > ins_exp_r);
  assign can_hit  = !ptr_end && (CMP_W'(id_r[pidx]) == CMP_W'(cid_r));
  assign do_ins   = cmd.ins_step && ins_stop;
  assign do_rem   = (cmd.can_step && can_hit) || cmd.pop;
  assign rem_ptr  = cmd.pop ? '0 : ptr_r;
  assign is_add   = (in_action == ACT_ADD_REL) || (in_action == ACT_ADD_ABS);

  always_comb begin
    sts.full     = full;
    sts.ins_stop = ins_stop;
    sts.can_end  = ptr_end;
    sts.can_hit  = can_hit;
    sts.due      = (cnt_r != '0) && (exp_r[0] < time_r);
    sts.head_rep = rep_r[0];
    sts.out_free = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      next_id_r   <= '0;
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        ptr_r <= '0;
        if (in_action == ACT_TICK) begin
          time_r <= time_r + TIME_BITS'(1);
        end
        if (is_add && !full) begin
          next_id_r <= nid;
        end
      end else if (cmd.pop) begin
        ptr_r <= '0;
      end else if ((cmd.ins_step && !ins_stop) || (cmd.can_step && !ptr_end && !can_hit)) begin
        ptr_r <= ptr_r + PTR_W'(1);
      end
      if (do_ins) begin
        cnt_r <= cnt_r + PTR_W'(1);
      end else if (do_rem) begin
        cnt_r <= cnt_r - PTR_W'(1);
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cid_r <= cancel_id;
      if (is_add && !full) begin
        ins_exp_r <= (in_action == ACT_ADD_REL) ? rel_exp : TIME_BITS'(abs_time);
        ins_id_r  <= nid;
        ins_per_r <= delay;
        ins_rep_r <= (in_action == ACT_ADD_REL) && repeat_req;
      end
    end else if (cmd.pop) begin
      ins_exp_r <= pop_exp;
      ins_id_r  <= id_r[0];
      ins_per_r <= per_r[0];
      ins_rep_r <= rep_r[0];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (PTR_W'(g) == ptr_r) begin
          exp_r[g] <= ins_exp_r;
          id_r[g]  <= ins_id_r;
          per_r[g] <= ins_per_r;
          rep_r[g] <= ins_rep_r;
        end else if (PTR_W'(g) > ptr_r) begin
          if (g > 0) begin
            exp_r[g] <= exp_r[(g > 0) ? g - 1 : 0];
            id_r[g]  <= id_r[(g > 0) ? g - 1 : 0];
            per_r[g] <= per_r[(g > 0) ? g - 1 : 0];
            rep_r[g] <= rep_r[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (do_rem) begin
        if ((g < DEPTH - 1) && (PTR_W'(g) >= rem_ptr)) begin
          exp_r[g] <= exp_r[(g < DEPTH - 1) ? g + 1 : g];
          id_r[g]  <= id_r[(g < DEPTH - 1) ? g + 1 : g];
          per_r[g] <= per_r[(g < DEPTH - 1) ? g + 1 : g];
          rep_r[g] <= rep_r[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_last_r <= cmd.last;
      unique case (cmd.sel)
        RES_ADD_OK: begin
          out_kind_r   <= KIND_ADD;
          out_status_r <= ST_OK;
          out_id_r     <= RID_W'(ins_id_r);
        end
        RES_FULL: begin
          out_kind_r   <= KIND_ADD;
          out_status_r <= ST_FULL;
          out_id_r     <= '0;
        end
        RES_CAN_OK: begin
          out_kind_r   <= KIND_CANCEL;
          out_status_r <= ST_OK;
          out_id_r     <= RID_W'(cid_r);
        end
        RES_CAN_MISS: begin
          out_kind_r   <= KIND_CANCEL;
          out_status_r <= ST_NOT_FOUND;
          out_id_r     <= '0;
        end
        default: begin
          out_kind_r   <= KIND_EXPIRE;
          out_status_r <= ST_OK;
          out_id_r     <= RID_W'(ins_id_r);
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_id_r, out_status_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PTR_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> cnt_r == PTR_W'($past(cnt_r) + PTR_W'(1)))
    else $error("insert did not grow the table");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_step |-> !full)
    else $error("insert scan on a full table");

  a_pop_due: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> sts.due)
    else $error("pop of a head timer that is not due");

endmodule
`default_nettype wire

@@ rtl/stq_ctrl.sv @@
// Sequencer for add, cancel and tick transfers of the timer queue.
`default_nettype none
module stq_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  stq_pkg::action_t  in_action,
  input  stq_pkg::sts_t     sts,
  output stq_pkg::cmd_t     cmd
);
  import stq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_CAN,
    S_CHECK,
    S_POP,
    S_EMIT
  } state_t;

  state_t         state_r;
  state_t         ret_r;
  res_sel_t       sel_r;
  logic           last_r;
  logic           tick_r;
  logic           pend_r;
  logic [K_W-1:0] k_r;

  logic           accept;
  logic           more;

  assign in_tready = state_r == S_IDLE;
  assign accept    = in_tvalid && in_tready;
  assign more      = (k_r != K_W'(RESULT_CAP)) && sts.due;

  always_comb begin
    cmd      = '0;
    cmd.sel  = sel_r;
    cmd.last = last_r;
    unique case (state_r)
      S_IDLE:  cmd.capture  = accept;
      S_INS:   cmd.ins_step = 1'b1;
      S_CAN:   cmd.can_step = 1'b1;
      S_POP:   cmd.pop      = 1'b1;
      S_EMIT:  cmd.push     = sts.out_free;
      default: cmd.capture  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      sel_r   <= RES_ADD_OK;
      last_r  <= 1'b0;
      tick_r  <= 1'b0;
      pend_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            tick_r <= in_action == ACT_TICK;
            k_r    <= '0;
            pend_r <= 1'b0;
            unique case (in_action)
              ACT_ADD_REL, ACT_ADD_ABS: begin
                if (sts.full) begin
                  sel_r   <= RES_FULL;
                  last_r  <= 1'b1;
                  ret_r   <= S_IDLE;
                  state_r <= S_EMIT;
                end else begin
                  state_r <= S_INS;
                end
              end
              ACT_CANCEL: state_r <= S_CAN;
              default:    state_r <= S_CHECK;
            endcase
          end
        end
        S_INS: begin
          if (sts.ins_stop) begin
            if (tick_r) begin
              state_r <= S_CHECK;
            end else begin
              sel_r   <= RES_ADD_OK;
              last_r  <= 1'b1;
              ret_r   <= S_IDLE;
              state_r <= S_EMIT;
            end
          end
        end
        S_CAN: begin
          if (sts.can_end || sts.can_hit) begin
            sel_r   <= sts.can_hit ? RES_CAN_OK : RES_CAN_MISS;
            last_r  <= 1'b1;
            ret_r   <= S_IDLE;
            state_r <= S_EMIT;
          end
        end
        S_CHECK: begin
          // previous expiry is sent only once we know whether another follows
          if (pend_r) begin
            pend_r  <= 1'b0;
            sel_r   <= RES_EXPIRE;
            last_r  <= !more;
            ret_r   <= more ? S_POP : S_IDLE;
            state_r <= S_EMIT;
          end else begin
            state_r <= more ? S_POP : S_IDLE;
          end
        end
        S_POP: begin
          k_r     <= k_r + K_W'(1);
          pend_r  <= 1'b1;
          state_r <= sts.head_rep ? S_INS : S_CHECK;
        end
        S_EMIT: begin
          if (sts.out_free) begin
            state_r <= ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= K_W'(RESULT_CAP))
    else $error("tick burst count beyond cap");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("expiry left unsent at end of tick");

endmodule
`default_nettype wire

@@ rtl/sorted_timer_queue_unit.sv @@
// Sorted timer queue top level: sequencer plus table datapath.
// Usage:
//   Input channel in_*: one transfer per command. in_tuser holds the action
//   (add relative, add absolute, cancel, tick); in_tdata holds the operands.
//   Output channel out_*: answers and expiries. out_tuser is the result kind,
//   out_tlast marks the final result that a command produces.
//   An add or a cancel gives one result. A tick gives one result per fired
//   timer, at most 16, and possibly none.
//   Sequencing: the table is walked one entry per clock by a single compare
//   port. An add walks until it finds its slot, or answers without a walk
//   when the table is full; a cancel walks until it finds its id or the
//   end. A tick checks the head; each due timer is popped, a repeating one
//   is put back by an insert walk, and its expiry is sent once the next
//   check shows whether another follows. in_tready is high only while the
//   sequencer is idle, in the cycle after the final result is written.
//   The output register holds one result; while the receiver stalls, the
//   sequencer waits before writing the next result, and a new command may be
//   taken while the last result is still waiting.
//   Reset (rst_n low, synchronous) empties the table, zeroes the clock and
//   the id counter; no clearing pass is needed.
`default_nettype none
module sorted_timer_queue_unit #(
  parameter int DEPTH     = 16,
  parameter int ID_BITS   = 16,
  parameter int TIME_BITS = 48
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // delay, repeat_req, absolute_time, cancel_id, zero pad
  input  wire  [stq_pkg::IN_DATA_W-1:0]     in_tdata,
  // action
  input  wire  [stq_pkg::ACTION_W-1:0]      in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // status, result_id, zero pad
  output logic [stq_pkg::OUT_DATA_W-1:0]    out_tdata,
  // kind
  output logic [stq_pkg::KIND_W-1:0]        out_tuser,
  output logic                              out_tlast
);
  import stq_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  action_t action;

  assign action = action_t'(in_tuser);

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (action),
    .sts       (sts),
    .cmd       (cmd)
  );

  stq_dp #(
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (action),
    .in_data    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
